### rtl/core/psg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package psg_pkg;

	// Command codes carried on the input channel
	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_READ  = 2'd1,
		CMD_TICK  = 2'd2
	} cmd_t;

	// Register map
	localparam logic [3:0] REG_NOISE_PERIOD = 4'd6;
	localparam logic [3:0] REG_MIXER        = 4'd7;
	localparam logic [3:0] REG_VOLUME_BASE  = 4'd8;

	// Volume register fields
	localparam int unsigned VOL_FORCE_BIT = 4;
	localparam logic [3:0] VOL_MAX = 4'hF;

	// Noise generator
	localparam int unsigned LFSR_W = 17;
	localparam logic [LFSR_W:0] LFSR_TAPS = 18'h24000;
	localparam int unsigned NOISE_CNT_W = 5;

	// Tone generator
	localparam int unsigned TONE_CNT_W = 12;

	// Mix width: three full-scale entries fit in 18 bits
	localparam int unsigned SUM_W = 18;

	// Divide by 3: floor(x * DIV3_RECIP / 2**DIV3_SHIFT) is exact for x < 2**19
	localparam int unsigned DIV3_SHIFT = 19;
	localparam logic [SUM_W-1:0] DIV3_RECIP = 18'd174763;

	// Logarithmic volume table, full scale 65535
	localparam logic [15:0] VOL_Q16 [16] = '{
		16'd0,     16'd511,   16'd721,   16'd1022,
		16'd1442,  16'd2038,  16'd2884,  16'd4076,
		16'd5767,  16'd8159,  16'd11534, 16'd16312,
		16'd23068, 16'd32623, 16'd46137, 16'd65535
	};

	// Per-channel controls for one tick
	typedef struct packed {
		logic tick;
		logic tone_off;
		logic noise_off;
		logic noise_level;
	} tone_ctrl_t;

endpackage

`default_nettype wire

### rtl/core/psg_cmd_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface psg_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] command;
	logic [3:0] reg_index;
	logic [7:0] write_data;

	modport source (output valid, command, reg_index, write_data, input ready);
	modport sink (input valid, command, reg_index, write_data, output ready);
endinterface

`default_nettype wire

### rtl/core/psg_res_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface psg_res_if;
	logic        valid;
	logic        ready;
	logic [7:0]  read_data;
	logic [15:0] sample;
	logic        is_sample;

	modport source (output valid, read_data, sample, is_sample, input ready);
	modport sink (input valid, read_data, sample, is_sample, output ready);
endinterface

`default_nettype wire

### rtl/core/psg_tone_ch.sv
`timescale 1ns / 1ps
`default_nettype none

module psg_tone_ch (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire psg_pkg::tone_ctrl_t ctrl,
	input  wire logic [11:0]        period,
	input  wire logic [7:0]         volume,
	output logic [15:0]             amp
);

	logic [psg_pkg::TONE_CNT_W-1:0] counter_q;
	logic                           level_q;
	logic [psg_pkg::TONE_CNT_W-1:0] period_eff;
	logic [psg_pkg::TONE_CNT_W:0]   cnt_inc;
	logic                           wrap;
	logic                           level_nxt;
	logic                           audible;
	logic [3:0]                     vol_idx;

	// Step the period counter; a zero period acts as one
	always_comb begin
		period_eff = (period == '0) ? psg_pkg::TONE_CNT_W'(1) : period;
		cnt_inc    = {1'b0, counter_q} + (psg_pkg::TONE_CNT_W + 1)'(1);
		wrap       = (cnt_inc >= {1'b0, period_eff});
		level_nxt  = level_q ^ wrap;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_q <= '0;
			level_q   <= 1'b0;
		end else if (ctrl.tick) begin
			counter_q <= wrap ? '0 : cnt_inc[psg_pkg::TONE_CNT_W-1:0];
			level_q   <= level_nxt;
		end
	end

	// Gate tone and noise, then look up the volume
	always_comb begin
		audible = (ctrl.tone_off | level_nxt) & (ctrl.noise_off | ctrl.noise_level);
		vol_idx = volume[psg_pkg::VOL_FORCE_BIT] ? psg_pkg::VOL_MAX : volume[3:0];
		amp     = audible ? psg_pkg::VOL_Q16[vol_idx] : 16'd0;
	end

endmodule

`default_nettype wire

### rtl/core/psg_tone_noise_generator.sv
// Tone and noise section of a three-channel programmable sound generator.
// Input channel (cmd) carries one word per operation: command 0 writes
// write_data into register reg_index, command 1 reads register reg_index,
// command 2 advances the generator by one sample tick; command 3 is dropped.
// Output channel (res) returns one word for each read (read_data, sample 0,
// is_sample 0) and each tick (sample, read_data 0, is_sample 1); writes
// return nothing.
// res.valid rises once its word has passed the input register, the state
// update and mix into the stage-2 register, and the divide-by-3 multiply
// into the output register. One word is accepted per cycle while res takes
// results; the pipeline handles back-to-back words and a read sees every
// earlier write.
// Reset clears all sixteen registers, the tone counters and levels, the
// noise counter and level, and loads the noise LFSR with one.
// When res is stalled, the pipeline fills its three stages and then drops
// cmd.ready; nothing is lost and state only advances as words move on.
`timescale 1ns / 1ps
`default_nettype none

module psg_tone_noise_generator #(
	parameter int unsigned TONE_CHANNELS = 3
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	psg_cmd_if.sink    cmd,
	psg_res_if.source  res
);

	localparam int unsigned NW = psg_pkg::NOISE_CNT_W;
	localparam int unsigned LW = psg_pkg::LFSR_W;
	localparam int unsigned SW = psg_pkg::SUM_W;

	// Pipeline handshake
	logic res_valid_q;
	logic s1_valid_q;
	logic s2_valid_q;
	logic out_en;
	logic s2_en;
	logic s1_en;
	logic s1_fire;
	logic do_write;
	logic do_read;
	logic do_tick;

	// Stage 1 word
	logic [1:0] cmd_s1;
	logic [3:0] idx_s1;
	logic [7:0] data_s1;

	// Stage 2 result
	logic [7:0]    rd_s2;
	logic [SW-1:0] sum_s2;
	logic          is_sample_s2;

	// Output register
	logic [7:0]  read_data_q;
	logic [15:0] sample_q;
	logic        is_sample_q;

	// Generator state
	logic [7:0]    rf_q [16];
	logic [NW-1:0] noise_cnt_q;
	logic [LW-1:0] lfsr_q;
	logic          noise_level_q;

	logic [NW-1:0]       noise_limit;
	logic [NW:0]         noise_inc;
	logic                noise_wrap;
	logic [LW:0]         lfsr_mix;
	logic [LW-1:0]       lfsr_nxt;
	logic [15:0]         amp [TONE_CHANNELS];
	logic [SW-1:0]       sum_nxt;
	logic [2*SW-1:0]     product;

	always_comb begin
		out_en   = !res_valid_q || res.ready;
		s2_en    = !s2_valid_q || out_en;
		s1_en    = !s1_valid_q || s2_en;
		s1_fire  = s1_valid_q && s2_en;
		do_write = s1_fire && (cmd_s1 == psg_pkg::CMD_WRITE);
		do_read  = s1_fire && (cmd_s1 == psg_pkg::CMD_READ);
		do_tick  = s1_fire && (cmd_s1 == psg_pkg::CMD_TICK);
	end

	assign cmd.ready = s1_en;

	// Capture the input word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s1_en) begin
			s1_valid_q <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_en && cmd.valid) begin
			cmd_s1  <= cmd.command;
			idx_s1  <= cmd.reg_index;
			data_s1 <= cmd.write_data;
		end
	end

	// Register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) begin
				rf_q[i] <= '0;
			end
		end else if (do_write) begin
			rf_q[idx_s1] <= data_s1;
		end
	end

	// Tone channels
	for (genvar c = 0; c < TONE_CHANNELS; c++) begin : g_ch
		localparam logic [3:0] LO_IDX  = 4'(2 * c);
		localparam logic [3:0] HI_IDX  = 4'(2 * c + 1);
		localparam logic [3:0] VOL_IDX = 4'(c) + psg_pkg::REG_VOLUME_BASE;

		psg_pkg::tone_ctrl_t ctrl;
		logic [11:0] period;

		always_comb begin
			ctrl.tick        = do_tick;
			ctrl.tone_off    = rf_q[psg_pkg::REG_MIXER][c];
			ctrl.noise_off   = rf_q[psg_pkg::REG_MIXER][c + 3];
			ctrl.noise_level = noise_level_q;
			period           = {rf_q[HI_IDX][3:0], rf_q[LO_IDX]};
		end

		psg_tone_ch u_ch (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.period (period),
			.volume (rf_q[VOL_IDX]),
			.amp    (amp[c])
		);
	end

	// Mix the channels
	always_comb begin
		sum_nxt = '0;
		for (int c = 0; c < TONE_CHANNELS; c++) begin
			sum_nxt = sum_nxt + SW'(amp[c]);
		end
	end

	// Noise counter and LFSR, stepped after the tone mix
	always_comb begin
		noise_limit = rf_q[psg_pkg::REG_NOISE_PERIOD][NW-1:0];
		if (noise_limit == '0) begin
			noise_limit = NW'(1);
		end
		noise_inc  = {1'b0, noise_cnt_q} + (NW + 1)'(1);
		noise_wrap = (noise_inc >= {1'b0, noise_limit});
		lfsr_mix   = {1'b0, lfsr_q} ^ (lfsr_q[0] ? psg_pkg::LFSR_TAPS : '0);
		lfsr_nxt   = lfsr_mix[LW:1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			noise_cnt_q   <= '0;
			lfsr_q        <= LW'(1);
			noise_level_q <= 1'b0;
		end else if (do_tick) begin
			noise_cnt_q <= noise_wrap ? '0 : noise_inc[NW-1:0];
			if (noise_wrap) begin
				lfsr_q        <= lfsr_nxt;
				noise_level_q <= lfsr_nxt[0];
			end
		end
	end

	// Stage 2: hold the read byte or the raw mix
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
		end else if (s2_en) begin
			s2_valid_q <= do_read || do_tick;
		end
	end

	always_ff @(posedge clk) begin
		if (do_read || do_tick) begin
			rd_s2        <= do_tick ? 8'd0 : rf_q[idx_s1];
			sum_s2       <= do_tick ? sum_nxt : '0;
			is_sample_s2 <= do_tick;
		end
	end

	// Divide the mix by 3 through the reciprocal
	assign product = {{SW{1'b0}}, sum_s2} * {{SW{1'b0}}, psg_pkg::DIV3_RECIP};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_en) begin
			res_valid_q <= s2_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (out_en && s2_valid_q) begin
			read_data_q <= rd_s2;
			sample_q    <= product[psg_pkg::DIV3_SHIFT +: 16];
			is_sample_q <= is_sample_s2;
		end
	end

	assign res.valid     = res_valid_q;
	assign res.read_data = read_data_q;
	assign res.sample    = sample_q;
	assign res.is_sample = is_sample_q;

endmodule

`default_nettype wire

### bench/tb.sv
`timescale 1ns / 1ps

module tb;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned RANDOM_PER_PHASE = 157;

	// Logarithmic volume steps scaled to 65535
	localparam logic [15:0] LEVEL_TO_Q16 [16] = '{
		16'd0,     16'd511,   16'd721,   16'd1022,
		16'd1442,  16'd2038,  16'd2884,  16'd4076,
		16'd5767,  16'd8159,  16'd11534, 16'd16312,
		16'd23068, 16'd32623, 16'd46137, 16'd65535
	};

	typedef struct {
		logic [7:0]  read_data;
		logic [15:0] sample;
		logic        is_sample;
	} psg_word_t;

	logic clk;
	logic arst_n;

	psg_cmd_if cmd_if ();
	psg_res_if res_if ();

	psg_tone_noise_generator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_if),
		.res    (res_if)
	);

	// Shadow copy of the generator state
	logic [7:0]  reg_shadow [16];
	logic [11:0] tone_ctr [3];
	logic        tone_phase [3];
	logic [4:0]  noise_ctr;
	logic [16:0] lfsr_state;
	logic        noise_bit;

	psg_word_t   pending_words [$];
	int unsigned mismatch_count;
	int unsigned cycle_count;
	int unsigned sender_idle_pct;
	int unsigned receiver_stall_pct;

	// Clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Run watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d words outstanding", $time, pending_words.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Random backpressure on the result side
	always @(posedge clk) begin
		res_if.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
	end

	// Advance tone and noise by one tick and return the mixed level
	function automatic logic [15:0] step_generator();
		logic [17:0] mix;
		logic [12:0] period;
		logic [12:0] count;
		logic [5:0]  noise_limit;
		logic [5:0]  ncount;
		logic [17:0] shifted;
		logic [7:0]  vol;
		logic [3:0]  level;
		logic        tone_on;
		logic        noise_on;
		mix = '0;
		for (int ch = 0; ch < 3; ch++) begin
			period = {1'b0, reg_shadow[2 * ch + 1][3:0], reg_shadow[2 * ch]};
			if (period == 0)
				period = 13'd1;
			count = {1'b0, tone_ctr[ch]} + 13'd1;
			if (count >= period) begin
				count = '0;
				tone_phase[ch] = ~tone_phase[ch];
			end
			tone_ctr[ch] = count[11:0];
			// noise_bit still holds the value from before this tick
			tone_on = reg_shadow[psg_pkg::REG_MIXER][ch] | tone_phase[ch];
			noise_on = reg_shadow[psg_pkg::REG_MIXER][ch + 3] | noise_bit;
			if (tone_on && noise_on) begin
				vol = reg_shadow[psg_pkg::REG_VOLUME_BASE + ch];
				level = vol[psg_pkg::VOL_FORCE_BIT] ? psg_pkg::VOL_MAX : vol[3:0];
				mix = mix + LEVEL_TO_Q16[level];
			end
		end
		noise_limit = {1'b0, reg_shadow[psg_pkg::REG_NOISE_PERIOD][4:0]};
		if (noise_limit == 0)
			noise_limit = 6'd1;
		ncount = {1'b0, noise_ctr} + 6'd1;
		if (ncount >= noise_limit) begin
			ncount = '0;
			shifted = {1'b0, lfsr_state};
			if (shifted[0])
				shifted = shifted ^ 18'h24000;
			shifted = shifted >> 1;
			lfsr_state = shifted[16:0];
			noise_bit = lfsr_state[0];
		end
		noise_ctr = ncount[4:0];
		return 16'(mix / 3);
	endfunction

	// Apply one accepted word to the shadow state and queue its result
	task automatic predict_word(input logic [1:0] op, input logic [3:0] idx,
			input logic [7:0] data);
		psg_word_t w;
		case (op)
			psg_pkg::CMD_WRITE: begin
				reg_shadow[idx] = data;
			end
			psg_pkg::CMD_READ: begin
				w.read_data = reg_shadow[idx];
				w.sample = '0;
				w.is_sample = 1'b0;
				pending_words.push_back(w);
			end
			psg_pkg::CMD_TICK: begin
				w.read_data = '0;
				w.sample = step_generator();
				w.is_sample = 1'b1;
				pending_words.push_back(w);
			end
			default: begin
			end
		endcase
	endtask

	task automatic report_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	// Check each result word; sampled at negedge so it is stable for the next edge
	always @(negedge clk) begin
		psg_word_t w;
		if (arst_n && res_if.valid && res_if.ready) begin
			if (pending_words.size() == 0) begin
				$display("%0t: unexpected word read_data %0d sample %0d is_sample %0d",
					$time, res_if.read_data, res_if.sample, res_if.is_sample);
				mismatch_count++;
			end else begin
				w = pending_words.pop_front();
				report_field("read_data", w.read_data, res_if.read_data);
				report_field("sample", w.sample, res_if.sample);
				report_field("is_sample", w.is_sample, res_if.is_sample);
			end
		end
	end

	// Send one word, with random idle cycles ahead of it
	task automatic send_word(input logic [1:0] op, input logic [3:0] idx,
			input logic [7:0] data);
		bit parked;
		bit taken;
		parked = 1'b0;
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			if (!parked) begin
				cmd_if.valid <= 1'b0;
				parked = 1'b1;
			end
			@(posedge clk);
		end
		cmd_if.valid <= 1'b1;
		cmd_if.command <= op;
		cmd_if.reg_index <= idx;
		cmd_if.write_data <= data;
		do begin
			@(negedge clk);
			taken = cmd_if.ready;
			@(posedge clk);
		end while (!taken);
		predict_word(op, idx, data);
	endtask

	task automatic write_reg(input logic [3:0] idx, input logic [7:0] data);
		send_word(psg_pkg::CMD_WRITE, idx, data);
	endtask

	task automatic read_reg(input logic [3:0] idx);
		send_word(psg_pkg::CMD_READ, idx, 8'($urandom));
	endtask

	task automatic tick_once();
		send_word(psg_pkg::CMD_TICK, 4'($urandom), 8'($urandom));
	endtask

	// Hold off the sender until every queued result is back
	task automatic hold_until_drained();
		cmd_if.valid <= 1'b0;
		@(posedge clk);
		while (pending_words.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_reset_contents();
		read_reg(4'd0);
		read_reg(4'd15);
	endtask

	// All gates open: forced level, full level and zero level
	task automatic test_mixer_volume();
		write_reg(psg_pkg::REG_VOLUME_BASE, 8'h1F);
		write_reg(psg_pkg::REG_VOLUME_BASE + 4'd1, 8'h0F);
		write_reg(psg_pkg::REG_VOLUME_BASE + 4'd2, 8'h00);
		write_reg(psg_pkg::REG_MIXER, 8'hFF);
		tick_once();
	endtask

	// Longest period on channel 0, shortest on channel 1, noise gates open
	task automatic test_tone_periods();
		write_reg(4'd0, 8'hFF);
		write_reg(4'd1, 8'hFF);
		write_reg(4'd2, 8'h01);
		write_reg(4'd3, 8'h00);
		write_reg(psg_pkg::REG_MIXER, 8'h38);
		tick_once();
		tick_once();
		read_reg(4'd1);
	endtask

	task automatic test_noise();
		write_reg(psg_pkg::REG_NOISE_PERIOD, 8'h1F);
		write_reg(psg_pkg::REG_MIXER, 8'h07);
		tick_once();
	endtask

	// Drop channel 0 period below its running count
	task automatic test_lowered_period();
		write_reg(4'd1, 8'h00);
		write_reg(4'd0, 8'h00);
		tick_once();
	endtask

	// Unused command must leave no trace
	task automatic test_unused_command();
		send_word(CMD_UNUSED, 4'd0, 8'h5A);
		read_reg(4'd0);
	endtask

	// Random traffic biased toward short periods so tones and noise move
	task automatic test_random_traffic(input int unsigned idle_pct,
			input int unsigned stall_pct, input bit with_pause);
		int unsigned pick;
		logic [3:0]  idx;
		logic [7:0]  data;
		sender_idle_pct = idle_pct;
		receiver_stall_pct = stall_pct;
		for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
			if (with_pause && n == RANDOM_PER_PHASE / 2)
				hold_until_drained();
			pick = $urandom_range(0, 99);
			idx = 4'($urandom_range(0, 15));
			data = 8'($urandom_range(0, 255));
			if (pick < 55) begin
				tick_once();
			end else if (pick < 80) begin
				if ($urandom_range(0, 4) != 0) begin
					case (idx)
						4'd0, 4'd2, 4'd4: data = 8'($urandom_range(0, 12));
						4'd1, 4'd3, 4'd5: data = {data[7:4], 4'd0};
						default: begin
						end
					endcase
				end
				write_reg(idx, data);
			end else if (pick < 95) begin
				read_reg(idx);
			end else begin
				send_word(CMD_UNUSED, idx, data);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cycle_count = 0;
		mismatch_count = 0;
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		cmd_if.valid = 1'b0;
		cmd_if.command = psg_pkg::CMD_WRITE;
		cmd_if.reg_index = '0;
		cmd_if.write_data = '0;
		res_if.ready = 1'b0;
		for (int i = 0; i < 16; i++)
			reg_shadow[i] = '0;
		for (int i = 0; i < 3; i++) begin
			tone_ctr[i] = '0;
			tone_phase[i] = 1'b0;
		end
		noise_ctr = '0;
		lfsr_state = 17'd1;
		noise_bit = 1'b0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_contents();
		test_mixer_volume();
		test_tone_periods();
		test_noise();
		test_lowered_period();
		test_unused_command();

		test_random_traffic(0, 0, 1'b0);
		test_random_traffic(68, 0, 1'b1);
		test_random_traffic(0, 68, 1'b0);
		test_random_traffic(26, 26, 1'b0);

		// Let the pipeline empty, then give stray words time to show up
		hold_until_drained();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
